/* rtl/cbz_pkg.sv */
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the piecewise cubic Bezier evaluator: item
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // Fixed field widths
  localparam int unsigned T_W     = 17;   // Q1.16 parameter, 65536 = 1.0
  localparam int unsigned COORD_W = 32;   // signed Q16.16 coordinate
  localparam int unsigned WGT_W   = 25;   // Q1.24 Bernstein weight, up to 1.0
  localparam int unsigned ACC_W   = 60;   // exact sum of four point*weight
  localparam int unsigned RND_SH  = 24;   // weight and blend rounding shift

  // Segment capacity, tied to the 5-bit segment count and 6-bit point index
  localparam int unsigned MAX_SEGMENTS = 16;

  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes
  localparam int unsigned REG_SEG_COUNT = 0;
  localparam logic [4:0]  SEG_COUNT_RST = 5'd1;

  typedef enum logic [1:0] {
    OP_LOAD        = 2'd0,
    OP_EVAL        = 2'd1,
    OP_SWEEP_COUNT = 2'd2,
    OP_SWEEP_STEP  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_DIV,
    S_TT,
    S_SEG,
    S_SQ,
    S_CUBE,
    S_WGT,
    S_MAC,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic       capture;     // latch item fields, reset sample counter
    logic       cap_single;  // item yields exactly one sample
    logic       wr_point;    // write one control point
    logic       div_start;   // start the step division
    logic       step_ld;     // take the quotient as sweep increment
    logic       t_adv;       // advance the sweep parameter
    logic       k_inc;       // count one emitted sample
    logic       acc_clr;     // clear blend accumulators
    logic       mac_rd_en;   // read one control point for the blend
    logic [1:0] mac_idx;     // point within the segment
    logic       emit;        // load the output register
    logic       emit_last;
    logic       emit_trunc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic t_le_end;     // current parameter <= end
    logic next_le_end;  // parameter after one more step <= end
    logic last_count;   // current sample is the last of the count
    logic at_cap;       // current sample is the last one allowed
    logic out_free;     // output register can take a result
  } status_t;

endpackage

/* rtl/cbz_ram.sv */
// ----------------------------------------------------------------------------
// cbz_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbz_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 49
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cbz_div.sv */
// ----------------------------------------------------------------------------
// cbz_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbz_div #(
  parameter int unsigned NUM_W = 17,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in one dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/cbz_datapath.sv */
// ----------------------------------------------------------------------------
// cbz_datapath
// Sweep parameter, segment select, Bernstein weights, control point store,
// multiply-accumulate blend, rounding and the output register.
// ----------------------------------------------------------------------------
module cbz_datapath #(
  parameter int unsigned MAX_SWEEP_SAMPLES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbz_pkg::cmd_t       cmd_i,
  output cbz_pkg::status_t    status_o,
  input  logic [4:0]          seg_count_i,
  input  logic [5:0]          point_index_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic [16:0]         t_begin_i,
  input  logic [16:0]         t_end_i,
  input  logic [16:0]         t_step_i,
  input  logic [6:0]          sample_count_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic                last_sample_o,
  output logic                truncated_o
);

  localparam int unsigned MAX_SEGMENTS = cbz_pkg::MAX_SEGMENTS;
  localparam int unsigned T_W   = cbz_pkg::T_W;
  localparam int unsigned W_W   = cbz_pkg::WGT_W;
  localparam int unsigned A_W   = cbz_pkg::ACC_W;
  localparam int unsigned SH    = cbz_pkg::RND_SH;
  localparam int unsigned NW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned EW    = (NW > 5) ? NW : 5;
  localparam int unsigned SGW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SLOTS = 3 * MAX_SEGMENTS + 1;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(MAX_SWEEP_SAMPLES + 1);
  localparam int unsigned TTW   = T_W + NW;
  localparam int unsigned PW    = 2 * T_W + T_W;      // cube product width
  localparam int unsigned MW    = 32 + W_W + 1;       // point * weight width

  localparam logic [PW+1:0]          RND_W = (PW + 2)'(64'd1 << (SH - 1));
  localparam logic signed [A_W-1:0]  RND_A = A_W'(64'sd1 << (SH - 1));
  localparam logic signed [A_W-1:0]  SAT_HI = A_W'(64'sd2147483647);
  localparam logic signed [A_W-1:0]  SAT_LO = A_W'(-64'sd2147483648);

  // Item fields
  logic [T_W-1:0]        tb_q, te_q;
  logic [CW-1:0]         cnt_q, k_q;
  logic signed [18:0]    t_acc_q, inc_q;
  // Segment select and weights
  logic [TTW-1:0]        tt_q;
  logic [T_W-1:0]        u_q, s_q;
  logic [AW-1:0]         base_q;
  logic [2*T_W-1:0]      ss_q, su_q, uu_q;
  logic [PW-1:0]         p_q [4];
  logic [W_W-1:0]        w_q [4];
  // Blend
  logic [63:0]           rdata;
  logic                  rd_v_q, prod_v_q;
  logic [1:0]            rd_idx_q;
  logic signed [MW-1:0]  prod_x_q, prod_y_q;
  logic signed [A_W-1:0] acc_x_q, acc_y_q;
  // Output register
  logic                  out_valid_q, last_q, trunc_q;
  logic [31:0]           out_x_q, out_y_q;

  logic [NW-1:0]         n_c;
  logic [CW-1:0]         cnt_c;
  logic [T_W-1:0]        tb_sat, te_sat, t_use;
  logic [NW:0]           seg_raw;
  logic [SGW-1:0]        seg_sel;
  logic [T_W-1:0]        u_d;
  logic signed [17:0]    diff;
  logic [T_W-1:0]        mag;
  logic                  div_done;
  logic [T_W-1:0]        quo;
  logic signed [19:0]    t_next;
  logic [PW+1:0]         p3x [4];
  logic                  we;
  logic [W_W:0]          w_sel;
  logic                  out_free;

  function automatic logic [31:0] sat32(input logic signed [A_W-1:0] v);
    logic signed [A_W-1:0] r;
    r = (v + RND_A) >>> SH;
    if (r > SAT_HI) begin
      return 32'h7fff_ffff;
    end else if (r < SAT_LO) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  // Clamp segment count, parameters and sample count
  always_comb begin
    if (EW'(seg_count_i) == '0) begin
      n_c = NW'(1);
    end else if (EW'(seg_count_i) > EW'(MAX_SEGMENTS)) begin
      n_c = NW'(MAX_SEGMENTS);
    end else begin
      n_c = NW'(seg_count_i);
    end
    if (sample_count_i == '0) begin
      cnt_c = CW'(1);
    end else if (sample_count_i > 7'(MAX_SWEEP_SAMPLES)) begin
      cnt_c = CW'(MAX_SWEEP_SAMPLES);
    end else begin
      cnt_c = CW'(sample_count_i);
    end
    tb_sat = (t_begin_i > cbz_pkg::ONE_Q16) ? cbz_pkg::ONE_Q16 : t_begin_i;
    te_sat = (t_end_i > cbz_pkg::ONE_Q16) ? cbz_pkg::ONE_Q16 : t_end_i;
    t_use  = t_acc_q[18] ? '0 : t_acc_q[T_W-1:0];
  end

  // Capture the item, hold the sweep parameter and sample counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      t_acc_q <= '0;
    end else if (cmd_i.capture) begin
      k_q     <= '0;
      t_acc_q <= 19'(tb_sat);
    end else begin
      if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.t_adv) begin
        t_acc_q <= t_acc_q + inc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tb_q  <= tb_sat;
      te_q  <= te_sat;
      cnt_q <= cmd_i.cap_single ? CW'(1) : cnt_c;
      inc_q <= 19'(t_step_i);
    end else if (cmd_i.step_ld) begin
      inc_q <= diff[17] ? -19'(quo) : 19'(quo);
    end
  end

  // Step of a sweep by count: (end - begin) / (count - 1), toward zero
  always_comb begin
    diff = $signed({1'b0, te_q}) - $signed({1'b0, tb_q});
    mag  = diff[17] ? T_W'(-diff) : T_W'(diff);
  end

  cbz_div #(
    .NUM_W (T_W),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (mag),
    .den_i   (cnt_q - 1'b1),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Segment select: integer part of t*n, clamped to the last segment
  always_comb begin
    seg_raw = tt_q[TTW-1:16];
    if (seg_raw >= (NW + 1)'(n_c)) begin
      seg_sel = SGW'(n_c - 1'b1);
      u_d     = cbz_pkg::ONE_Q16;
    end else begin
      seg_sel = SGW'(seg_raw);
      u_d     = {1'b0, tt_q[15:0]};
    end
  end

  // Weight chain: t*n, then u and s, then squares, then cubes, then round
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p3x[i] = (i == 1 || i == 2) ? ((PW + 2)'(p_q[i]) + ((PW + 2)'(p_q[i]) << 1))
                                  : (PW + 2)'(p_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    tt_q   <= TTW'(t_use) * TTW'(n_c);
    u_q    <= u_d;
    s_q    <= cbz_pkg::ONE_Q16 - u_d;
    base_q <= AW'(seg_sel) * AW'(3);
    ss_q   <= (2 * T_W)'(s_q) * (2 * T_W)'(s_q);
    su_q   <= (2 * T_W)'(s_q) * (2 * T_W)'(u_q);
    uu_q   <= (2 * T_W)'(u_q) * (2 * T_W)'(u_q);
    p_q[0] <= PW'(ss_q) * PW'(s_q);
    p_q[1] <= PW'(ss_q) * PW'(u_q);
    p_q[2] <= PW'(su_q) * PW'(u_q);
    p_q[3] <= PW'(uu_q) * PW'(u_q);
    for (int i = 0; i < 4; i++) begin
      w_q[i] <= W_W'((p3x[i] + RND_W) >> SH);
    end
  end

  // Control point store, x in the upper half
  assign we = cmd_i.wr_point && (32'(point_index_i) < 32'(SLOTS));

  cbz_ram #(
    .WIDTH (64),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(point_index_i)),
    .wdata_i ({point_x_i, point_y_i}),
    .raddr_i (base_q + AW'(cmd_i.mac_idx)),
    .rdata_o (rdata)
  );

  // Blend: multiply each point by its weight, then accumulate
  assign w_sel = {1'b0, w_q[rd_idx_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.mac_rd_en;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cmd_i.mac_idx;
    prod_x_q <= $signed(rdata[63:32]) * $signed(w_sel);
    prod_y_q <= $signed(rdata[31:0]) * $signed(w_sel);
    if (cmd_i.acc_clr) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (prod_v_q) begin
      acc_x_q <= acc_x_q + A_W'(prod_x_q);
      acc_y_q <= acc_y_q + A_W'(prod_y_q);
    end
  end

  // Output register: round, saturate, hold until the transaction completes
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q <= sat32(acc_x_q);
      out_y_q <= sat32(acc_y_q);
      last_q  <= cmd_i.emit_last;
      trunc_q <= cmd_i.emit_trunc;
    end
  end

  // Status toward the controller
  assign t_next = {t_acc_q[18], t_acc_q} + {inc_q[18], inc_q};

  always_comb begin
    status_o.div_done    = div_done;
    status_o.t_le_end    = t_acc_q <= $signed({2'b00, te_q});
    status_o.next_le_end = t_next <= $signed({3'b000, te_q});
    status_o.last_count  = k_q == (cnt_q - 1'b1);
    status_o.at_cap      = k_q == CW'(MAX_SWEEP_SAMPLES - 1);
    status_o.out_free    = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign last_sample_o = last_q;
  assign truncated_o   = trunc_q;

  a_trunc_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && trunc_q |-> last_q)
    else $error("truncated result not flagged as last");

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over a pending one");

  a_k_below_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= CW'(MAX_SWEEP_SAMPLES - 1))
    else $error("sample counter beyond the sweep cap");

endmodule

/* rtl/cbz_ctrl.sv */
// ----------------------------------------------------------------------------
// cbz_ctrl
// Sequencer: takes items, runs the step division and walks each sample
// through the weight chain, the blend and the output register.
// ----------------------------------------------------------------------------
module cbz_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  cbz_pkg::status_t status_i,
  output cbz_pkg::cmd_t    cmd_o
);

  cbz_pkg::state_e state_q, state_d;
  cbz_pkg::op_e    mode_q, mode_d;
  logic [2:0]      mac_q, mac_d;
  logic            last;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbz_pkg::S_IDLE;
      mode_q  <= cbz_pkg::OP_LOAD;
      mac_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      mac_q   <= mac_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    mac_d      = mac_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    last       = (mode_q == cbz_pkg::OP_SWEEP_STEP)
                 ? (status_i.at_cap || !status_i.next_le_end)
                 : status_i.last_count;

    unique case (state_q)
      cbz_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cbz_pkg::op_e'(op_i) == cbz_pkg::OP_LOAD) begin
            cmd_o.wr_point = 1'b1;
          end else begin
            cmd_o.capture    = 1'b1;
            cmd_o.cap_single = cbz_pkg::op_e'(op_i) == cbz_pkg::OP_EVAL;
            mode_d           = cbz_pkg::op_e'(op_i);
            state_d          = cbz_pkg::S_CHK;
          end
        end
      end
      cbz_pkg::S_CHK: begin
        priority if (mode_q == cbz_pkg::OP_SWEEP_COUNT && !status_i.last_count) begin
          cmd_o.div_start = 1'b1;
          state_d         = cbz_pkg::S_DIV;
        end else if (mode_q == cbz_pkg::OP_SWEEP_STEP && !status_i.t_le_end) begin
          state_d = cbz_pkg::S_IDLE;
        end else begin
          state_d = cbz_pkg::S_TT;
        end
      end
      cbz_pkg::S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.step_ld = 1'b1;
          state_d       = cbz_pkg::S_TT;
        end
      end
      cbz_pkg::S_TT:   state_d = cbz_pkg::S_SEG;
      cbz_pkg::S_SEG:  state_d = cbz_pkg::S_SQ;
      cbz_pkg::S_SQ:   state_d = cbz_pkg::S_CUBE;
      cbz_pkg::S_CUBE: state_d = cbz_pkg::S_WGT;
      cbz_pkg::S_WGT: begin
        cmd_o.acc_clr = 1'b1;
        mac_d         = '0;
        state_d       = cbz_pkg::S_MAC;
      end
      cbz_pkg::S_MAC: begin
        // Four reads, then let the multiply and accumulate drain
        cmd_o.mac_rd_en = mac_q < 3'd4;
        cmd_o.mac_idx   = mac_q[1:0];
        if (mac_q == 3'd5) begin
          state_d = cbz_pkg::S_EMIT;
        end else begin
          mac_d = mac_q + 1'b1;
        end
      end
      cbz_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_last  = last;
          cmd_o.emit_trunc = mode_q == cbz_pkg::OP_SWEEP_STEP && status_i.at_cap &&
                             status_i.next_le_end;
          if (last) begin
            state_d = cbz_pkg::S_IDLE;
          end else begin
            cmd_o.t_adv = 1'b1;
            cmd_o.k_inc = 1'b1;
            state_d     = cbz_pkg::S_TT;
          end
        end
      end
      default: state_d = cbz_pkg::S_IDLE;
    endcase
  end

  a_idle_no_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbz_pkg::S_IDLE |-> !cmd_o.emit && !cmd_o.mac_rd_en)
    else $error("datapath command issued while idle");

  a_div_then_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbz_pkg::S_DIV && status_i.div_done |=> state_q == cbz_pkg::S_TT)
    else $error("division finished without starting a sample");

  a_emit_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(state_q) == cbz_pkg::S_MAC || $past(state_q) == cbz_pkg::S_EMIT)
    else $error("result emitted before the blend completed");

endmodule

/* rtl/piecewise_cubic_bezier_eval.sv */
// ----------------------------------------------------------------------------
// piecewise_cubic_bezier_eval
// Evaluator for a chain of cubic Bezier segments with point loads, single
// evaluations and two kinds of parameter sweep.
// ----------------------------------------------------------------------------
// A load transaction writes one control point. Every evaluated sample passes
// through the five steps of the weight chain (t times the segment count,
// segment select, squares, cubes, weight rounding), then the blend, which
// reads the four control points one per cycle from the single read port of
// the point RAM and multiplies them by their weights, and then the load of
// the output register. Each evaluating transaction adds its accept and a
// check state, and a sweep by count of more than one sample adds its step
// division (one quotient bit per cycle). The output register holds each
// result until the result side takes it, and a sample waits before its load
// until the register is free. The input is taken again as soon as the last
// result is in the output register.
// ----------------------------------------------------------------------------
module piecewise_cubic_bezier_eval #(
  parameter int unsigned MAX_SWEEP_SAMPLES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic [16:0]        t_begin_i,
  input  logic [16:0]        t_end_i,
  input  logic [16:0]        t_step_i,
  input  logic [6:0]         sample_count_i,
  // Results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               last_sample_o,
  output logic               truncated_o
);

  logic [4:0]       seg_count_q;
  logic             reg_hit;
  cbz_pkg::cmd_t    cmd;
  cbz_pkg::status_t status;

  // Configuration register
  assign reg_hit = paddr == 3'(cbz_pkg::REG_SEG_COUNT * 4);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= cbz_pkg::SEG_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      seg_count_q <= pwdata[4:0];
    end
  end

  assign prdata = reg_hit ? 32'(seg_count_q) : '0;

  cbz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cbz_datapath #(
    .MAX_SWEEP_SAMPLES (MAX_SWEEP_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .seg_count_i    (seg_count_q),
    .point_index_i  (point_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .t_begin_i      (t_begin_i),
    .t_end_i        (t_end_i),
    .t_step_i       (t_step_i),
    .sample_count_i (sample_count_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .last_sample_o  (last_sample_o),
    .truncated_o    (truncated_o)
  );

endmodule
